@@ design/fbde_pkg.sv @@
// ----------------------------------------------------------------------------
// Framebuffer draw engine package
// Shared widths, codes, controller/datapath interface types and the RGB565
// colour conversion functions.
// ----------------------------------------------------------------------------
package fbde_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 12;
    localparam int SRC_W      = 11;
    localparam int AREA_W     = 12;
    localparam int COLOR_W    = 24;
    localparam int PIX_W      = 16;
    localparam int SPAN_W     = 14;
    localparam int SXY_W      = 13;
    localparam int LIN_W      = 24;
    localparam int SRC_LIN_W  = 26;
    localparam int MUL_A_W    = 13;
    localparam int PROD_W     = MUL_A_W + AREA_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [AREA_W-1:0] AREA_WIDTH_RST  = AREA_W'(64);
    localparam logic [AREA_W-1:0] AREA_HEIGHT_RST = AREA_W'(64);

    typedef enum logic [1:0] {
        OP_SET_PIXEL = 2'd0,
        OP_GET_PIXEL = 2'd1,
        OP_FILL_RECT = 2'd2,
        OP_COPY_RECT = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_WIDTH  = 2'd0,
        CFG_AREA_HEIGHT = 2'd1,
        CFG_NATIVE_MODE = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_ADDR,
        ST_PIX_EXEC,
        ST_RECT_SETUP,
        ST_RECT_SRC,
        ST_ROW_START,
        ST_FILL,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic mul_dst;
        logic mul_src;
        logic row_begin;
        logic row_next;
        logic col_next;
        logic mem_write;
        logic write_copy;
        logic mem_read;
        logic read_src;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic clr_last;
        logic px_ok;
        logic row_live;
        logic pix_live;
        logic src_ok;
        logic out_busy;
    } sts_t;

    function automatic logic [PIX_W-1:0] pack565(input logic [COLOR_W-1:0] c,
                                                 input logic native);
        logic [PIX_W-1:0] p;
        if (native)
        begin
            p = c[PIX_W-1:0];
        end
        else
        begin
            p = {c[23:19], c[15:10], c[7:3]};
        end
        return p;
    endfunction

    function automatic logic [COLOR_W-1:0] unpack565(input logic [PIX_W-1:0] p,
                                                     input logic native);
        logic [COLOR_W-1:0] c;
        if (native)
        begin
            c = {8'd0, p};
        end
        else
        begin
            c = {p[15:11], 3'd0, p[10:5], 2'd0, p[4:0], 3'd0};
        end
        return c;
    endfunction

endpackage

@@ design/rgb565_framebuffer_draw_engine.sv @@
// ----------------------------------------------------------------------------
// RGB565 framebuffer draw engine
// Set pixel, get pixel, fill rectangle and copy rectangle over a 16-bit pixel
// store addressed as x + y * area_width.
// ----------------------------------------------------------------------------
// After reset the engine clears all MAX_WIDTH * MAX_HEIGHT pixel store
// entries (4096 with the default parameters) and holds in_ready low until
// that pass is complete; configuration writes are taken at any time. One
// transaction is worked on at a time. A set or get pixel multiplies y by the
// stride, then accesses the store, then loads the result. A fill writes the
// rectangle clipped to the area row by row, and a copy walks it the same way,
// reading and then writing each pixel in separate states, since the store
// has a single read port. Every command returns one result, which waits in
// an output register while the next command is accepted.
module rgb565_framebuffer_draw_engine
    import fbde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [COORD_W-1:0]    dest_x,
    input  logic [COORD_W-1:0]    dest_y,
    input  logic [SIZE_W-1:0]     rect_width,
    input  logic [SIZE_W-1:0]     rect_height,
    input  logic [SRC_W-1:0]      source_x,
    input  logic [SRC_W-1:0]      source_y,
    input  logic [COLOR_W-1:0]    color_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COLOR_W-1:0]    color_out,
    output logic                  clipped,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    fbde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fbde_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (opcode),
        .dest_x      (dest_x),
        .dest_y      (dest_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .source_x    (source_x),
        .source_y    (source_y),
        .color_in    (color_in),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .color_out   (color_out),
        .clipped     (clipped)
    );

endmodule

@@ design/fbde_ctrl.sv @@
// ----------------------------------------------------------------------------
// Framebuffer draw engine controller
// State machine that sequences the store clearing pass, single pixel
// transactions and the row/column walk of fill and copy rectangles.
// ----------------------------------------------------------------------------
module fbde_ctrl
    import fbde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] opcode,
    output logic       in_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    op_t    in_op;

    assign in_op = op_t'(opcode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == OP_SET_PIXEL || in_op == OP_GET_PIXEL)
                    begin
                        state_next = ST_PIX_ADDR;
                    end
                    else
                    begin
                        state_next = ST_RECT_SETUP;
                    end
                end
            end
            ST_PIX_ADDR:
            begin
                state_next = ST_PIX_EXEC;
            end
            ST_PIX_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_RECT_SETUP:
            begin
                if (sts.op == OP_COPY_RECT)
                begin
                    state_next = ST_RECT_SRC;
                end
                else
                begin
                    state_next = ST_ROW_START;
                end
            end
            ST_RECT_SRC:
            begin
                state_next = ST_ROW_START;
            end
            ST_ROW_START:
            begin
                if (!sts.row_live)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.op == OP_COPY_RECT)
                begin
                    state_next = ST_COPY_RD;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (!sts.pix_live)
                begin
                    state_next = ST_ROW_START;
                end
            end
            ST_COPY_RD:
            begin
                if (sts.pix_live)
                begin
                    state_next = ST_COPY_WR;
                end
                else
                begin
                    state_next = ST_ROW_START;
                end
            end
            ST_COPY_WR:
            begin
                state_next = ST_COPY_RD;
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_PIX_ADDR:
            begin
                cmd.mul_dst = 1'b1;
            end
            ST_PIX_EXEC:
            begin
                if (sts.op == OP_SET_PIXEL)
                begin
                    cmd.mem_write = sts.px_ok;
                end
                else
                begin
                    cmd.mem_read = sts.px_ok;
                end
            end
            ST_RECT_SETUP:
            begin
                cmd.mul_dst = 1'b1;
            end
            ST_RECT_SRC:
            begin
                cmd.mul_src = 1'b1;
            end
            ST_ROW_START:
            begin
                cmd.row_begin = sts.row_live;
            end
            ST_FILL:
            begin
                if (sts.pix_live)
                begin
                    cmd.mem_write = 1'b1;
                    cmd.col_next  = 1'b1;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                end
            end
            ST_COPY_RD:
            begin
                if (sts.pix_live)
                begin
                    cmd.mem_read = sts.src_ok;
                    cmd.read_src = 1'b1;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                end
            end
            ST_COPY_WR:
            begin
                cmd.mem_write  = 1'b1;
                cmd.write_copy = 1'b1;
                cmd.col_next   = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_result = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ design/fbde_datapath.sv @@
// ----------------------------------------------------------------------------
// Framebuffer draw engine datapath
// Configuration registers, captured command, rectangle walk counters, address
// arithmetic, the pixel store and the result register.
// ----------------------------------------------------------------------------
module fbde_datapath
    import fbde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [1:0]            opcode,
    input  logic [COORD_W-1:0]    dest_x,
    input  logic [COORD_W-1:0]    dest_y,
    input  logic [SIZE_W-1:0]     rect_width,
    input  logic [SIZE_W-1:0]     rect_height,
    input  logic [SRC_W-1:0]      source_x,
    input  logic [SRC_W-1:0]      source_y,
    input  logic [COLOR_W-1:0]    color_in,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [COLOR_W-1:0]    color_out,
    output logic                  clipped
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [LIN_W-1:0]     DEPTH_LIN     = LIN_W'(DEPTH);
    localparam logic [SRC_LIN_W-1:0] DEPTH_SRC_LIN = SRC_LIN_W'(DEPTH);
    localparam logic [ADDR_W-1:0]    LAST_ADDR     = ADDR_W'(DEPTH - 1);

    logic [AREA_W-1:0]  area_width_reg;
    logic [AREA_W-1:0]  area_height_reg;
    logic               native_mode_reg;

    op_t                op_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [SIZE_W-1:0]  w_reg;
    logic [SIZE_W-1:0]  h_reg;
    logic [SRC_W-1:0]   sx_reg;
    logic [SRC_W-1:0]   sy_reg;
    logic [COLOR_W-1:0] color_reg;

    logic [AREA_W-1:0]        row_reg;
    logic [AREA_W-1:0]        col_reg;
    logic [AREA_W-1:0]        x0_reg;
    logic signed [SPAN_W-1:0] x1_reg;
    logic signed [SPAN_W-1:0] y1_reg;
    logic [SXY_W-1:0]         srcx0_reg;
    logic [SXY_W-1:0]         srcx_reg;
    logic [SXY_W-1:0]         srcy_reg;
    logic [LIN_W-1:0]         dst_base_reg;
    logic [SRC_LIN_W-1:0]     src_base_reg;

    logic [ADDR_W-1:0]  clr_reg;
    logic [PIX_W-1:0]   rd_data_reg;
    logic               rd_ok_reg;

    logic               out_valid_reg;
    logic [COLOR_W-1:0] color_out_reg;
    logic               clipped_reg;

    logic [PIX_W-1:0]   store [DEPTH];

    logic                     x_neg;
    logic                     y_neg;
    logic [AREA_W-1:0]        x0;
    logic [AREA_W-1:0]        y0;
    logic [AREA_W-1:0]        skip_x;
    logic [AREA_W-1:0]        skip_y;
    logic signed [SPAN_W-1:0] x_end;
    logic signed [SPAN_W-1:0] y_end;
    logic signed [SPAN_W-1:0] aw_s;
    logic signed [SPAN_W-1:0] ah_s;
    logic signed [SPAN_W-1:0] x1;
    logic signed [SPAN_W-1:0] y1;
    logic [SXY_W-1:0]         srcx0;
    logic [SXY_W-1:0]         srcy0;
    logic                     in_area;
    logic [MUL_A_W-1:0]       mul_a;
    logic [PROD_W-1:0]        product;
    logic [LIN_W-1:0]         dst_addr;
    logic [SRC_LIN_W-1:0]     src_addr;
    logic                     dst_in_depth;
    logic [PIX_W-1:0]         read_value;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [PIX_W-1:0]         mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_width_reg  <= AREA_WIDTH_RST;
            area_height_reg <= AREA_HEIGHT_RST;
            native_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_AREA_WIDTH:  area_width_reg  <= cfg_data;
                CFG_AREA_HEIGHT: area_height_reg <= cfg_data;
                CFG_NATIVE_MODE: native_mode_reg <= cfg_data[0];
                default:
                begin
                    native_mode_reg <= native_mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op_t'(opcode);
            x_reg     <= dest_x;
            y_reg     <= dest_y;
            w_reg     <= rect_width;
            h_reg     <= rect_height;
            sx_reg    <= source_x;
            sy_reg    <= source_y;
            color_reg <= color_in;
        end
    end

    assign x_neg  = x_reg[COORD_W-1];
    assign y_neg  = y_reg[COORD_W-1];
    assign x0     = x_neg ? '0 : x_reg;
    assign y0     = y_neg ? '0 : y_reg;
    assign skip_x = x_neg ? (~x_reg + AREA_W'(1)) : '0;
    assign skip_y = y_neg ? (~y_reg + AREA_W'(1)) : '0;
    assign x_end  = $signed({{2{x_reg[COORD_W-1]}}, x_reg}) + $signed({2'b00, w_reg});
    assign y_end  = $signed({{2{y_reg[COORD_W-1]}}, y_reg}) + $signed({2'b00, h_reg});
    assign aw_s   = $signed({2'b00, area_width_reg});
    assign ah_s   = $signed({2'b00, area_height_reg});
    assign x1     = (x_end > aw_s) ? aw_s : x_end;
    assign y1     = (y_end > ah_s) ? ah_s : y_end;
    assign srcx0  = {2'b00, sx_reg} + {1'b0, skip_x};
    assign srcy0  = {2'b00, sy_reg} + {1'b0, skip_y};
    assign in_area = !x_neg && !y_neg && (x_reg < area_width_reg)
                     && (y_reg < area_height_reg);

    assign mul_a   = cmd.mul_src ? srcy_reg : {1'b0, y0};
    assign product = PROD_W'(mul_a) * PROD_W'(area_width_reg);

    assign dst_addr     = dst_base_reg + LIN_W'(col_reg);
    assign src_addr     = src_base_reg + SRC_LIN_W'(srcx_reg);
    assign dst_in_depth = dst_addr < DEPTH_LIN;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_dst)
        begin
            row_reg      <= y0;
            col_reg      <= x0;
            x0_reg       <= x0;
            x1_reg       <= x1;
            y1_reg       <= y1;
            srcx0_reg    <= srcx0;
            srcy_reg     <= srcy0;
            dst_base_reg <= product[LIN_W-1:0];
        end
        else
        begin
            if (cmd.mul_src)
            begin
                src_base_reg <= SRC_LIN_W'(product);
            end
            if (cmd.row_begin)
            begin
                col_reg  <= x0_reg;
                srcx_reg <= srcx0_reg;
            end
            else if (cmd.col_next)
            begin
                col_reg  <= col_reg + AREA_W'(1);
                srcx_reg <= srcx_reg + SXY_W'(1);
            end
            if (cmd.row_next)
            begin
                row_reg      <= row_reg + AREA_W'(1);
                srcy_reg     <= srcy_reg + SXY_W'(1);
                dst_base_reg <= dst_base_reg + LIN_W'(area_width_reg);
                src_base_reg <= src_base_reg + SRC_LIN_W'(area_width_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture || cmd.read_src || cmd.mem_read)
            begin
                rd_ok_reg <= cmd.mem_read;
            end
            if (cmd.clear_wr && clr_reg != LAST_ADDR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
        end
    end

    assign read_value = rd_ok_reg ? rd_data_reg : '0;
    assign mem_we     = cmd.clear_wr || cmd.mem_write;
    assign mem_waddr  = cmd.clear_wr ? clr_reg : dst_addr[ADDR_W-1:0];
    assign mem_raddr  = cmd.read_src ? src_addr[ADDR_W-1:0] : dst_addr[ADDR_W-1:0];

    always_comb
    begin
        if (cmd.clear_wr)
        begin
            mem_wdata = '0;
        end
        else if (cmd.write_copy)
        begin
            mem_wdata = read_value;
        end
        else
        begin
            mem_wdata = pack565(color_reg, native_mode_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            rd_data_reg <= store[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            color_out_reg <= (op_reg == OP_GET_PIXEL)
                             ? unpack565(read_value, native_mode_reg) : '0;
            clipped_reg   <= (op_reg == OP_SET_PIXEL || op_reg == OP_GET_PIXEL) && !in_area;
        end
    end

    assign out_valid = out_valid_reg;
    assign color_out = color_out_reg;
    assign clipped   = clipped_reg;

    assign sts.op       = op_reg;
    assign sts.clr_last = clr_reg == LAST_ADDR;
    assign sts.px_ok    = in_area && dst_in_depth;
    assign sts.row_live = ($signed({2'b00, row_reg}) < y1_reg) && (dst_base_reg < DEPTH_LIN);
    assign sts.pix_live = ($signed({2'b00, col_reg}) < x1_reg) && dst_in_depth;
    assign sts.src_ok   = (srcx_reg < {1'b0, area_width_reg})
                          && (srcy_reg < {1'b0, area_height_reg})
                          && (src_addr < DEPTH_SRC_LIN);
    assign sts.out_busy = out_valid_reg && !out_ready;

endmodule

@@ design/fbde_checker.sv @@
// ----------------------------------------------------------------------------
// Framebuffer draw engine port checker
// Concurrent assertions on the top-level ports, bound to the draw engine.
// ----------------------------------------------------------------------------
module fbde_checker
    import fbde_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COLOR_W-1:0]    color_out,
    input logic                  clipped
);

    // A stalled result must hold its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(color_out) && $stable(clipped))
    else $error("result changed while stalled");

    // A clipped pixel never carries a colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> color_out == '0)
    else $error("clipped result with non-zero colour");

    // The input is never ready in the cycle after a transaction is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted on consecutive cycles");

    // The store clearing pass keeps the input closed straight after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
    else $error("input open before the clearing pass");

endmodule

bind rgb565_framebuffer_draw_engine fbde_checker u_fbde_checker (.*);

@@ sim/tb_rgb565_framebuffer_draw_engine.sv @@
// ----------------------------------------------------------------------------
// Testbench for the RGB565 framebuffer draw engine
// Drives set, get, fill and copy commands through the valid/ready channels
// and changes the drawing area and pixel mode between phases. A model of the
// pixel store predicts each reply, and a scoreboard compares it field by field.
// ----------------------------------------------------------------------------
module tb_rgb565_framebuffer_draw_engine;
    import fbde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int STALL_LIMIT = 50000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 46;
    localparam int PH_WIDTH  [PHASES] = '{64, 64, 1, 2048, 0, 64, 4095, 100, 37, 2048, 64};
    localparam int PH_HEIGHT [PHASES] = '{64, 64, 2048, 1, 64, 0, 4095, 50, 111, 2048, 64};
    localparam int PH_NATIVE [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};

    typedef struct {
        op_t                op;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic [SRC_W-1:0]   sx;
        logic [SRC_W-1:0]   sy;
        logic [COLOR_W-1:0] color;
    } draw_cmd_t;

    class draw_scoreboard;
        typedef struct {
            logic [COLOR_W-1:0] color;
            logic               clip;
        } pixel_reply_t;

        logic [PIX_W-1:0] pixels [STORE_DEPTH];
        int               area_w;
        int               area_h;
        bit               native;
        pixel_reply_t     awaited_replies [$];
        int               errors;

        function new();
            foreach (pixels[i])
            begin
                pixels[i] = '0;
            end
            area_w = 64;
            area_h = 64;
            native = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_AREA_WIDTH:  area_w = int'(value);
                CFG_AREA_HEIGHT: area_h = int'(value);
                CFG_NATIVE_MODE: native = value[0];
                default: ;
            endcase
        endfunction

        function logic [PIX_W-1:0] to565(logic [COLOR_W-1:0] c);
            if (native)
            begin
                return c[PIX_W-1:0];
            end
            return PIX_W'((((c >> 19) & 24'h1f) << 11) | (((c >> 10) & 24'h3f) << 5)
                          | ((c >> 3) & 24'h1f));
        endfunction

        function bit in_area(int x, int y);
            return x >= 0 && y >= 0 && x < area_w && y < area_h;
        endfunction

        function logic [PIX_W-1:0] read_pixel(int x, int y);
            int addr;
            if (!in_area(x, y))
            begin
                return '0;
            end
            addr = x + y * area_w;
            return addr < STORE_DEPTH ? pixels[addr] : '0;
        endfunction

        function void write_pixel(int x, int y, logic [PIX_W-1:0] value);
            int addr;
            if (in_area(x, y))
            begin
                addr = x + y * area_w;
                if (addr < STORE_DEPTH)
                begin
                    pixels[addr] = value;
                end
            end
        endfunction

        // Pixels are visited top-down and left to right, so an overlapping copy
        // reads back pixels that it has already moved.
        function void paint_rect(int x, int y, int w, int h, bit copy, int sx, int sy,
                                 logic [PIX_W-1:0] value);
            int x0;
            int y0;
            int x1;
            int y1;
            x0 = x < 0 ? 0 : x;
            y0 = y < 0 ? 0 : y;
            x1 = x + w > area_w ? area_w : x + w;
            y1 = y + h > area_h ? area_h : y + h;
            for (int row = y0; row < y1; row++)
            begin
                if (row * area_w >= STORE_DEPTH)
                begin
                    break;
                end
                for (int col = x0; col < x1; col++)
                begin
                    if (col + row * area_w >= STORE_DEPTH)
                    begin
                        break;
                    end
                    if (copy)
                    begin
                        write_pixel(col, row, read_pixel(sx + col - x, sy + row - y));
                    end
                    else
                    begin
                        write_pixel(col, row, value);
                    end
                end
            end
        endfunction

        function void note_command(draw_cmd_t cmd);
            int               x;
            int               y;
            logic [PIX_W-1:0] p;
            pixel_reply_t     reply;
            x = int'($signed(cmd.dx));
            y = int'($signed(cmd.dy));
            reply.color = '0;
            reply.clip  = 1'b0;
            case (cmd.op)
                OP_SET_PIXEL:
                begin
                    if (!in_area(x, y))
                    begin
                        reply.clip = 1'b1;
                    end
                    else
                    begin
                        write_pixel(x, y, to565(cmd.color));
                    end
                end
                OP_GET_PIXEL:
                begin
                    if (!in_area(x, y))
                    begin
                        reply.clip = 1'b1;
                    end
                    else
                    begin
                        p = read_pixel(x, y);
                        if (native)
                        begin
                            reply.color = COLOR_W'(p);
                        end
                        else
                        begin
                            reply.color = (COLOR_W'(p >> 11) << 19)
                                        | (COLOR_W'((p >> 5) & 16'h3f) << 10)
                                        | (COLOR_W'(p & 16'h1f) << 3);
                        end
                    end
                end
                OP_FILL_RECT:
                begin
                    paint_rect(x, y, int'(cmd.w), int'(cmd.h), 1'b0, 0, 0, to565(cmd.color));
                end
                default:
                begin
                    paint_rect(x, y, int'(cmd.w), int'(cmd.h), 1'b1, int'(cmd.sx),
                               int'(cmd.sy), '0);
                end
            endcase
            awaited_replies.push_back(reply);
        endfunction

        function void check_reply(logic [COLOR_W-1:0] color, logic clip);
            pixel_reply_t want;
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: reply with none expected, color_out %06h clipped %0b",
                         $time, color, clip);
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            if (color !== want.color)
            begin
                $display("%0t: color_out expected %06h actual %06h", $time, want.color, color);
                errors++;
            end
            if (clip !== want.clip)
            begin
                $display("%0t: clipped expected %0b actual %0b", $time, want.clip, clip);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_replies.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            opcode;
    logic [COORD_W-1:0]    dest_x;
    logic [COORD_W-1:0]    dest_y;
    logic [SIZE_W-1:0]     rect_width;
    logic [SIZE_W-1:0]     rect_height;
    logic [SRC_W-1:0]      source_x;
    logic [SRC_W-1:0]      source_y;
    logic [COLOR_W-1:0]    color_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [COLOR_W-1:0]    color_out;
    logic                  clipped;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    draw_scoreboard sb = new();
    bit             steady = 1'b0;
    int             cur_w = 64;
    int             cur_h = 64;
    bit             big_ok = 1'b1;
    int             idle_cycles = 0;

    rgb565_framebuffer_draw_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .dest_x      (dest_x),
        .dest_y      (dest_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .source_x    (source_x),
        .source_y    (source_y),
        .color_in    (color_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .color_out   (color_out),
        .clipped     (clipped),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic draw_cmd_t make_cmd(op_t op, int x, int y, int w, int h,
                                           int sx, int sy, logic [COLOR_W-1:0] c);
        draw_cmd_t cmd;
        cmd.op    = op;
        cmd.dx    = COORD_W'(x);
        cmd.dy    = COORD_W'(y);
        cmd.w     = SIZE_W'(w);
        cmd.h     = SIZE_W'(h);
        cmd.sx    = SRC_W'(sx);
        cmd.sy    = SRC_W'(sy);
        cmd.color = c;
        return cmd;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(int span);
        int sel;
        int lim;
        sel = $urandom_range(0, 9);
        lim = (span > 80 && sel < 4) ? 80 : (span > 2047 ? 2047 : span);
        if (sel < 7)
        begin
            return COORD_W'($urandom_range(0, lim));
        end
        if (sel == 7)
        begin
            return COORD_W'($urandom);
        end
        if (sel == 8)
        begin
            return COORD_W'(0 - int'($urandom_range(1, 3)));
        end
        return COORD_W'(span - 1 + int'($urandom_range(0, 2)));
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            return '0;
        end
        if (sel == 1)
        begin
            return big_ok ? SIZE_W'($urandom_range(0, 2048)) : SIZE_W'($urandom_range(0, 32));
        end
        return SIZE_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [SRC_W-1:0] pick_source(int span);
        if ($urandom_range(0, 9) < 8)
        begin
            return SRC_W'($urandom_range(0, span > 80 ? 80 : span));
        end
        return SRC_W'($urandom_range(0, 2047));
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t cmd;
        int        sel;
        sel = $urandom_range(0, 19);
        if (sel < 7)
        begin
            cmd.op = OP_SET_PIXEL;
        end
        else if (sel < 14)
        begin
            cmd.op = OP_GET_PIXEL;
        end
        else if (sel < 17)
        begin
            cmd.op = OP_FILL_RECT;
        end
        else
        begin
            cmd.op = OP_COPY_RECT;
        end
        cmd.dx    = pick_coord(cur_w);
        cmd.dy    = pick_coord(cur_h);
        cmd.w     = pick_size();
        cmd.h     = pick_size();
        cmd.sx    = pick_source(cur_w);
        cmd.sy    = pick_source(cur_h);
        cmd.color = COLOR_W'($urandom);
        return cmd;
    endfunction

    // Entered and left at a falling edge; valid stays high when the next
    // transaction follows without a gap.
    task automatic send_cmd(draw_cmd_t cmd);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode      = cmd.op;
        dest_x      = cmd.dx;
        dest_y      = cmd.dy;
        rect_width  = cmd.w;
        rect_height = cmd.h;
        source_x    = cmd.sx;
        source_y    = cmd.sy;
        color_in    = cmd.color;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_command(cmd);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, CFG_DATA_W'(value));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_reply(color_out, clipped);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = OP_SET_PIXEL;
        dest_x      = '0;
        dest_y      = '0;
        rect_width  = '0;
        rect_height = '0;
        source_x    = '0;
        source_y    = '0;
        color_in    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_AREA_WIDTH;
        cfg_data    = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_cmd(make_cmd(OP_SET_PIXEL, 0, 0, 0, 0, 0, 0, 24'hffffff));
        send_cmd(make_cmd(OP_GET_PIXEL, 0, 0, 0, 0, 0, 0, 24'h000000));
        send_cmd(make_cmd(OP_SET_PIXEL, 63, 63, 0, 0, 0, 0, 24'h123456));
        send_cmd(make_cmd(OP_GET_PIXEL, 63, 63, 0, 0, 0, 0, 24'hffffff));
        send_cmd(make_cmd(OP_SET_PIXEL, -1, 0, 0, 0, 0, 0, 24'h00ff00));
        send_cmd(make_cmd(OP_SET_PIXEL, 64, 5, 0, 0, 0, 0, 24'h00ff00));
        send_cmd(make_cmd(OP_GET_PIXEL, 0, 64, 0, 0, 0, 0, 24'h000000));
        send_cmd(make_cmd(OP_GET_PIXEL, -2048, -2048, 0, 0, 0, 0, 24'h000000));
        send_cmd(make_cmd(OP_SET_PIXEL, 2047, 2047, 0, 0, 0, 0, 24'hffffff));
        send_cmd(make_cmd(OP_FILL_RECT, -5, -5, 10, 10, 0, 0, 24'h00ff00));
        send_cmd(make_cmd(OP_FILL_RECT, 10, 10, 0, 5, 0, 0, 24'hff00ff));
        send_cmd(make_cmd(OP_FILL_RECT, 10, 10, 5, 0, 0, 0, 24'hff00ff));
        send_cmd(make_cmd(OP_FILL_RECT, 60, 60, 2048, 2048, 0, 0, 24'hff0000));
        send_cmd(make_cmd(OP_GET_PIXEL, 62, 62, 0, 0, 0, 0, 24'h000000));
        send_cmd(make_cmd(OP_COPY_RECT, 1, 1, 8, 8, 0, 0, 24'h000000));
        send_cmd(make_cmd(OP_GET_PIXEL, 8, 8, 0, 0, 0, 0, 24'h000000));
        send_cmd(make_cmd(OP_COPY_RECT, 20, 20, 4, 4, 2047, 2047, 24'h000000));
        send_cmd(make_cmd(OP_COPY_RECT, 0, 0, 0, 3, 60, 60, 24'h000000));
        send_cmd(make_cmd(OP_FILL_RECT, 0, 0, 2048, 2048, 0, 0, 24'h0aaaaa));
        send_cmd(make_cmd(OP_COPY_RECT, 32, 0, 2048, 2048, 0, 0, 24'h000000));
        send_cmd(make_cmd(OP_GET_PIXEL, 40, 40, 0, 0, 0, 0, 24'h000000));
        send_cmd(make_cmd(OP_GET_PIXEL, 20, 20, 0, 0, 0, 0, 24'h000000));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_reg(CFG_AREA_WIDTH, PH_WIDTH[ph]);
            write_reg(CFG_AREA_HEIGHT, PH_HEIGHT[ph]);
            write_reg(CFG_NATIVE_MODE, PH_NATIVE[ph]);
            cur_w  = PH_WIDTH[ph];
            cur_h  = PH_HEIGHT[ph];
            big_ok = cur_w * cur_h <= 8192;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 15 == 0)
                begin
                    steady = $urandom_range(0, 2) == 0;
                end
                send_cmd(random_cmd());
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/fbde_pkg.sv
design/fbde_ctrl.sv
design/fbde_datapath.sv
design/rgb565_framebuffer_draw_engine.sv
design/fbde_checker.sv
sim/tb_rgb565_framebuffer_draw_engine.sv
